// ===== src/assert_macros.svh =====
// Assertion helpers shared by the height window average RTL.
// HWA_ASSERT is disabled while rst_n is low; HWA_ASSERT_ALWAYS checks on every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HWA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HWA_ASSERT(lbl, prop, msg)
`define HWA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/hwa_pkg.sv =====
package hwa_pkg;

  // Window geometry and sample format
  localparam int WINDOW_SIZE = 8;
  localparam int SAMPLE_BITS = 12;
  localparam int POS_W       = $clog2(WINDOW_SIZE);
  localparam int SUM_W       = SAMPLE_BITS + $clog2(WINDOW_SIZE);

  // Q8.8 scale into Q12.4 height: numerator gets 4 + 8 fraction bits
  localparam int FRAC_SHIFT  = 12;
  localparam int SCALE_W     = 16;
  localparam int VALUE_W     = 16;

  // Serial divider sizes
  localparam int DVD_W       = SAMPLE_BITS + FRAC_SHIFT;
  localparam int DVS_W       = SCALE_W;
  localparam int DCNT_W      = $clog2(DVD_W);

  // Configuration port
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_OFFSET  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNTS_PER_MM = 1'd1;

  localparam logic [SAMPLE_BITS-1:0] OFFSET_RESET = {SAMPLE_BITS{1'b1}};
  localparam logic [SCALE_W-1:0]     SCALE_RESET  = 16'd256;

  // Request commands and result kinds
  localparam logic [1:0] CMD_SAMPLE      = 2'd0;
  localparam logic [1:0] CMD_CAPTURE_OFS = 2'd1;
  localparam logic [1:0] CMD_CAPTURE_REF = 2'd2;

  localparam logic [1:0] KIND_HEIGHT     = 2'd0;
  localparam logic [1:0] KIND_OFFSET     = 2'd1;
  localparam logic [1:0] KIND_REFERENCE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_GO,
    ST_AVG_RUN,
    ST_HGT_RUN,
    ST_PUT
  } hwa_state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } hwa_div_stat_t;

endpackage

// ===== src/hwa_window.sv =====
`include "assert_macros.svh"

module hwa_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [hwa_pkg::SAMPLE_BITS-1:0] sample,
  output logic [hwa_pkg::SUM_W-1:0]     sum
);
  import hwa_pkg::*;

  logic [SAMPLE_BITS-1:0] win_r [WINDOW_SIZE];
  logic [POS_W-1:0]       wr_pos_r, wr_pos_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0] oldest;

  // Drop the oldest sample from the running sum, add the new one
  always_comb begin
    oldest     = win_r[wr_pos_r];
    sum_nxt    = sum_r - SUM_W'(oldest) + SUM_W'(sample);
    wr_pos_nxt = (wr_pos_r == POS_W'(WINDOW_SIZE - 1)) ? '0 : wr_pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        win_r[i] <= '0;
      end
      wr_pos_r <= '0;
      sum_r    <= '0;
    end else if (push) begin
      win_r[wr_pos_r] <= sample;
      wr_pos_r        <= wr_pos_nxt;
      sum_r           <= sum_nxt;
    end
  end

  assign sum = sum_r;

  `HWA_ASSERT(a_wr_pos_range, wr_pos_r <= POS_W'(WINDOW_SIZE - 1), "write position past window")

endmodule

// ===== src/hwa_divider.sv =====
`include "assert_macros.svh"

module hwa_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [hwa_pkg::DVD_W-1:0]    dividend,
  input  logic [hwa_pkg::DVS_W-1:0]    divisor,
  output hwa_pkg::hwa_div_stat_t       stat,
  output logic [hwa_pkg::DVD_W-1:0]    quotient
);
  import hwa_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W:0]    trial;
  logic [DVS_W+1:0]  diff;
  logic              fits;

  // One restoring step per cycle: dividend bits leave at the top, quotient bits enter below
  always_comb begin
    trial    = {rem_r, quo_r[DVD_W-1]};
    diff     = {1'b0, trial} - {2'b00, dvs_r};
    fits     = !diff[DVS_W+1];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (busy_r) begin
      rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  `HWA_ASSERT(a_done_not_busy, done_r |-> !busy_r, "divider done while still busy")
  `HWA_ASSERT(a_step_count, busy_r |-> (cnt_r <= DCNT_W'(DVD_W - 1)), "divider step count overrun")

endmodule

// ===== src/height_window_average_unit.sv =====
// Height window average unit: keeps a sliding window of the last WINDOW_SIZE raw samples
// with a running sum, and on every WINDOW_SIZE-th sample request emits the height
// (offset - average) * 4096 / counts_per_mm in Q12.4, clamped at zero and saturated.
// Capture requests answer with the last raw sample (zero before any sample); capture
// offset also loads it as the active offset once a sample has arrived. A sample request
// that emits nothing and a capture request leave the unit idle. A sample request that
// emits a height stalls the input until its height enters the output register: the window
// average and the height scaling (skipped when the height clamps to zero) both run through
// one shared bit-serial restoring divider, one quotient bit per cycle. Results wait in an
// output register; while it is full and stalled, the input stalls too, so any out_stall
// time lengthens the stall.
`include "assert_macros.svh"

module height_window_average_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_command,
  input  logic [hwa_pkg::SAMPLE_BITS-1:0]   in_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_kind,
  output logic [hwa_pkg::VALUE_W-1:0]       out_value,
  input  logic                              cfg_we,
  input  logic [hwa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [hwa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import hwa_pkg::*;

  hwa_state_t             state_r, state_nxt;
  logic [POS_W-1:0]       count_r, count_nxt;
  logic [SAMPLE_BITS-1:0] offset_r, offset_nxt;
  logic [SCALE_W-1:0]     scale_r, scale_nxt;
  logic [SAMPLE_BITS-1:0] last_r, last_nxt;
  logic                   have_r, have_nxt;
  logic [VALUE_W-1:0]     res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_kind_r, out_kind_nxt;
  logic [VALUE_W-1:0]     out_value_r, out_value_nxt;

  logic                   in_take;
  logic                   out_free;
  logic                   push;
  logic [SUM_W-1:0]       win_sum;
  logic                   div_start;
  logic [DVD_W-1:0]       div_dividend;
  logic [DVS_W-1:0]       div_divisor;
  hwa_div_stat_t          div_stat;
  logic [DVD_W-1:0]       div_quo;
  logic [SAMPLE_BITS-1:0] avg;
  logic [SAMPLE_BITS-1:0] height_diff;
  logic                   quo_sat;

  hwa_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .sample (in_sample),
    .sum    (win_sum)
  );

  hwa_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_take  = in_valid && !in_stall;
  assign push     = in_take && (in_command == CMD_SAMPLE);

  assign avg         = div_quo[SAMPLE_BITS-1:0];
  assign height_diff = offset_r - avg;
  assign quo_sat     = |div_quo[DVD_W-1:VALUE_W];

  // Sequence requests, the two divider passes and the result hand-off
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    offset_nxt    = offset_r;
    scale_nxt     = scale_r;
    last_nxt      = last_r;
    have_nxt      = have_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    div_start     = 1'b0;
    div_dividend  = DVD_W'(win_sum);
    div_divisor   = DVS_W'(WINDOW_SIZE);

    // Register writes must arrive only while idle; the block itself does not enforce this
    if (cfg_we) begin
      case (cfg_addr)
        REG_INIT_OFFSET:   offset_nxt = cfg_wdata[SAMPLE_BITS-1:0];
        REG_COUNTS_PER_MM: scale_nxt  = cfg_wdata[SCALE_W-1:0];
        default:           ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          case (in_command)
            CMD_SAMPLE: begin
              last_nxt = in_sample;
              have_nxt = 1'b1;
              if (count_r == POS_W'(WINDOW_SIZE - 1)) begin
                count_nxt = '0;
                state_nxt = ST_AVG_GO;
              end else begin
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_CAPTURE_OFS: begin
              if (have_r) begin
                offset_nxt = last_r;
              end
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_OFFSET;
              out_value_nxt = VALUE_W'(last_r);
            end
            CMD_CAPTURE_REF: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_REFERENCE;
              out_value_nxt = VALUE_W'(last_r);
            end
            default: ;
          endcase
        end
      end
      ST_AVG_GO: begin
        div_start = 1'b1;
        state_nxt = ST_AVG_RUN;
      end
      ST_AVG_RUN: begin
        div_dividend = {height_diff, {FRAC_SHIFT{1'b0}}};
        div_divisor  = scale_r;
        if (div_stat.done) begin
          if (offset_r > avg) begin
            div_start = 1'b1;
            state_nxt = ST_HGT_RUN;
          end else begin
            res_nxt   = '0;
            state_nxt = ST_PUT;
          end
        end
      end
      ST_HGT_RUN: begin
        if (div_stat.done) begin
          res_nxt   = quo_sat ? {VALUE_W{1'b1}} : div_quo[VALUE_W-1:0];
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_HEIGHT;
          out_value_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      offset_r    <= OFFSET_RESET;
      scale_r     <= SCALE_RESET;
      last_r      <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      offset_r    <= offset_nxt;
      scale_r     <= scale_nxt;
      last_r      <= last_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r       <= res_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;

  `HWA_ASSERT(a_no_take_while_div, !(in_take && div_stat.busy), "request taken during division")
  `HWA_ASSERT(a_div_running, ((state_r == ST_AVG_RUN) || (state_r == ST_HGT_RUN)) |-> (div_stat.busy || div_stat.done), "divider idle while a pass is pending")
  `HWA_ASSERT(a_sample_before_height, (state_r == ST_AVG_GO) |-> have_r, "height started without a sample")

endmodule
